>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared widths and types for the point to segment distance core
// Coordinate width, derived arithmetic widths and the beat that runs
// through the square root cell chain.
// ----------------------------------------------------------------------------
package psd_pkg;

   // input coordinate width
   localparam int COORD_BITS = 16;

   // differences of two coordinates
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // product of two differences, and a sum of two products
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   // squared lengths and cross magnitude are all below 2^(2*COORD_BITS+1)
   localparam int W_BITS     = 2 * COORD_BITS + 1;
   localparam int CM_BITS    = W_BITS;

   // split of the cross magnitude for squaring in partial products
   localparam int HALF_BITS  = (CM_BITS + 1) / 2;
   localparam int HI_BITS    = CM_BITS - HALF_BITS;
   localparam int TGT_BITS   = 2 * CM_BITS;

   // result width, one root bit per cell
   localparam int DIST_BITS  = 17;
   localparam int POS_BITS   = $clog2(DIST_BITS);

   // accumulator of t*t*w inside a cell
   localparam int ACC_RAW    = 2 * DIST_BITS + W_BITS;
   localparam int ACC_BITS   = (ACC_RAW > TGT_BITS + 1) ? ACC_RAW : TGT_BITS + 1;
   localparam int QACC_BITS  = DIST_BITS + W_BITS;

   // beat handed from cell to cell
   typedef struct packed {
      logic [TGT_BITS-1:0]  target;   // bound on t*t*w
      logic [W_BITS-1:0]    w;        // weight: squared length or one
      logic [ACC_BITS-1:0]  p;        // r*r*w so far
      logic [QACC_BITS-1:0] q;        // r*w so far
      logic [DIST_BITS-1:0] r;        // root bits found so far
      logic                 on;
      logic                 degen;
   } cell_data_type;

endpackage

>>> rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front: geometry front end
// Differences, products, projection test and root operand selection.
// Six pipeline stages, each with its own valid bit.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [psd_pkg::COORD_BITS-1:0]       seg_start_x,
   input  logic [psd_pkg::COORD_BITS-1:0]       seg_start_y,
   input  logic [psd_pkg::COORD_BITS-1:0]       seg_end_x,
   input  logic [psd_pkg::COORD_BITS-1:0]       seg_end_y,
   input  logic [psd_pkg::COORD_BITS-1:0]       probe_x,
   input  logic [psd_pkg::COORD_BITS-1:0]       probe_y,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output psd_pkg::cell_data_type               out_data
);
   import psd_pkg::*;

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] ready;

   // stage 1: differences
   logic signed [DIFF_BITS-1:0] dx_ff, dy_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   // stage 2: products
   logic signed [PROD_BITS-1:0] dxdx_ff, dydy_ff, dxqx_ff, dyqy_ff, dxqy_ff, dyqx_ff;
   logic signed [PROD_BITS-1:0] qxqx_ff, qyqy_ff, rxrx_ff, ryry_ff;
   // stage 3: sums
   logic signed [SUM_BITS-1:0]  dd_ff, dot_ff, cr_ff, qa_ff, qb_ff;
   // stage 4: decision
   logic                        on4_ff, dg4_ff;
   logic [CM_BITS-1:0]          cm4_ff;
   logic [W_BITS-1:0]           dd4_ff, e4_ff;
   // stage 5: partial products of the cross magnitude squared
   logic                        on5_ff, dg5_ff;
   logic [W_BITS-1:0]           dd5_ff, e5_ff;
   logic [2*HI_BITS-1:0]        hh5_ff;
   logic [HI_BITS+HALF_BITS-1:0] hl5_ff;
   logic [2*HALF_BITS-1:0]      ll5_ff;
   // stage 6: cell chain beat
   cell_data_type               data6_ff;

   // ready chain, bubbles collapse
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_data  = data6_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // stage 4 combinational decision
   logic                 degen_c, on_c;
   logic signed [SUM_BITS-1:0] cr_abs_c;
   logic signed [SUM_BITS-1:0] e_c;
   always_comb begin
      degen_c  = (dd_ff == '0);
      on_c     = !degen_c && !dot_ff[SUM_BITS-1] && (dot_ff <= dd_ff);
      cr_abs_c = cr_ff[SUM_BITS-1] ? -cr_ff : cr_ff;
      e_c      = (degen_c || qa_ff <= qb_ff) ? qa_ff : qb_ff;
   end

   // stage 6 combinational target
   logic [TGT_BITS-1:0] cm_sq_c;
   always_comb begin
      cm_sq_c = (TGT_BITS'(hh5_ff) << (2 * HALF_BITS))
              + (TGT_BITS'(hl5_ff) << (HALF_BITS + 1))
              + TGT_BITS'(ll5_ff);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         dx_ff <= {seg_end_x[COORD_BITS-1], seg_end_x} - {seg_start_x[COORD_BITS-1], seg_start_x};
         dy_ff <= {seg_end_y[COORD_BITS-1], seg_end_y} - {seg_start_y[COORD_BITS-1], seg_start_y};
         qx_ff <= {probe_x[COORD_BITS-1], probe_x} - {seg_start_x[COORD_BITS-1], seg_start_x};
         qy_ff <= {probe_y[COORD_BITS-1], probe_y} - {seg_start_y[COORD_BITS-1], seg_start_y};
         rx_ff <= {probe_x[COORD_BITS-1], probe_x} - {seg_end_x[COORD_BITS-1], seg_end_x};
         ry_ff <= {probe_y[COORD_BITS-1], probe_y} - {seg_end_y[COORD_BITS-1], seg_end_y};
      end
      if (ready[1]) begin
         dxdx_ff <= dx_ff * dx_ff;
         dydy_ff <= dy_ff * dy_ff;
         dxqx_ff <= dx_ff * qx_ff;
         dyqy_ff <= dy_ff * qy_ff;
         dxqy_ff <= dx_ff * qy_ff;
         dyqx_ff <= dy_ff * qx_ff;
         qxqx_ff <= qx_ff * qx_ff;
         qyqy_ff <= qy_ff * qy_ff;
         rxrx_ff <= rx_ff * rx_ff;
         ryry_ff <= ry_ff * ry_ff;
      end
      if (ready[2]) begin
         dd_ff  <= SUM_BITS'(dxdx_ff) + SUM_BITS'(dydy_ff);
         dot_ff <= SUM_BITS'(dxqx_ff) + SUM_BITS'(dyqy_ff);
         cr_ff  <= SUM_BITS'(dxqy_ff) - SUM_BITS'(dyqx_ff);
         qa_ff  <= SUM_BITS'(qxqx_ff) + SUM_BITS'(qyqy_ff);
         qb_ff  <= SUM_BITS'(rxrx_ff) + SUM_BITS'(ryry_ff);
      end
      if (ready[3]) begin
         on4_ff <= on_c;
         dg4_ff <= degen_c;
         cm4_ff <= cr_abs_c[CM_BITS-1:0];
         dd4_ff <= dd_ff[W_BITS-1:0];
         e4_ff  <= e_c[W_BITS-1:0];
      end
      if (ready[4]) begin
         on5_ff <= on4_ff;
         dg5_ff <= dg4_ff;
         dd5_ff <= dd4_ff;
         e5_ff  <= e4_ff;
         hh5_ff <= cm4_ff[CM_BITS-1:HALF_BITS] * cm4_ff[CM_BITS-1:HALF_BITS];
         hl5_ff <= cm4_ff[CM_BITS-1:HALF_BITS] * cm4_ff[HALF_BITS-1:0];
         ll5_ff <= cm4_ff[HALF_BITS-1:0] * cm4_ff[HALF_BITS-1:0];
      end
      if (ready[5]) begin
         data6_ff.target <= on5_ff ? cm_sq_c : TGT_BITS'(e5_ff);
         data6_ff.w      <= on5_ff ? dd5_ff : W_BITS'(1);
         data6_ff.p      <= '0;
         data6_ff.q      <= '0;
         data6_ff.r      <= '0;
         data6_ff.on     <= on5_ff;
         data6_ff.degen  <= dg5_ff;
      end
   end

endmodule

>>> rtl/psd_cell.sv
// ----------------------------------------------------------------------------
// psd_cell: one bit of the weighted square root search
// Tries root bit pos: keeps it when (r | 2^pos)^2 * w <= target. The running
// products r*r*w and r*w are updated by shifts and adds only.
// ----------------------------------------------------------------------------
module psd_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [psd_pkg::POS_BITS-1:0]  pos,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  psd_pkg::cell_data_type        in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output psd_pkg::cell_data_type        out_data
);
   import psd_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;

   logic [ACC_BITS-1:0] cand;
   logic                keep;

   // trial bit
   always_comb begin
      cand = in_data.p
           + (ACC_BITS'(in_data.q) << (pos + 1))
           + (ACC_BITS'(in_data.w) << (2 * pos));
      keep = (cand <= ACC_BITS'(in_data.target));
      data_in = in_data;
      if (keep) begin
         data_in.p = cand;
         data_in.q = in_data.q + (QACC_BITS'(in_data.w) << pos);
         data_in.r = in_data.r | (DIST_BITS'(1) << pos);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

endmodule

>>> rtl/point_segment_distance_core.sv
// ----------------------------------------------------------------------------
// point_segment_distance_core: distance from a point to a 2-D segment
// Floor of the exact distance, with projection and zero-length flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat: segment endpoints and the probe point, signed.
//   rsp_* returns one beat per request, in order: distance, on_segment and
//   degenerate. A beat moves when valid is high and stall is low.
//   The path is six front stages (differences, products, sums,
//   projection test, partial products of the cross term squared, operand
//   select) and a chain of 17 cells, one root bit each.
//   Throughput is one beat per cycle while rsp_stall is low; every stage
//   holds one beat, so the cell chain sets the pipeline depth.
//   When rsp_stall is high the last beat holds and stages fill in behind
//   it; req_stall rises only once every stage holds a beat.
//   Reset clears all valid bits; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module point_segment_distance_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_seg_start_x,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_seg_start_y,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_seg_end_x,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_seg_end_y,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_probe_x,
   input  logic [psd_pkg::COORD_BITS-1:0]      req_probe_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psd_pkg::DIST_BITS-1:0]       rsp_distance,
   output logic                                rsp_on_segment,
   output logic                                rsp_degenerate
);
   import psd_pkg::*;

   logic                front_ready;
   logic [DIST_BITS:0]  chain_valid;
   logic [DIST_BITS:0]  chain_ready;
   cell_data_type       chain_data [DIST_BITS+1];

   // front end
   psd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (front_ready),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .probe_x     (req_probe_x),
      .probe_y     (req_probe_y),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_data    (chain_data[0])
   );

   // root cells, top bit first
   for (genvar i = 0; i < DIST_BITS; i++) begin : g_cell
      psd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .pos       (POS_BITS'(DIST_BITS - 1 - i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign chain_ready[DIST_BITS] = !rsp_stall;
   assign req_stall      = !front_ready;
   assign rsp_valid      = chain_valid[DIST_BITS];
   assign rsp_distance   = chain_data[DIST_BITS].r;
   assign rsp_on_segment = chain_data[DIST_BITS].on;
   assign rsp_degenerate = chain_data[DIST_BITS].degen;

   // a degenerate segment never reports a projection
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_on_segment && rsp_degenerate))
      else $error("on_segment and degenerate both set");

   // an open output means the whole pipeline can move
   a_no_stall_when_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is open");

   // a stalled response beat is not dropped
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response beat lost under stall");

endmodule
